### hdl/mavg_pkg.sv
// mavg_pkg: shared widths, defaults and word layout for the moving-average
// filter bank. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mavg_pkg;

    localparam int DEF_CHANNELS   = 32;
    localparam int DEF_MAX_WINDOW = 32;

    localparam int CH_W     = 5;
    localparam int SMP_W    = 16;
    localparam int AVG_W    = 16;
    localparam int WIN_W    = 6;
    localparam int TDATA_W  = 24;

    localparam logic [WIN_W-1:0] WIN_RESET = 6'd8;

endpackage

`default_nettype wire

### hdl/mavg_ram.sv
// mavg_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mavg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                        i_clk,
    input  wire                                        i_we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                           i_wdata,
    input  wire                                        i_re,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/mavg_div.sv
// mavg_div: restoring divider, one quotient bit per cycle.
// Depends on nothing; used by moving_average_filter_bank.
`timescale 1ns / 1ps
`default_nettype none

module mavg_div #(
    parameter int N_W = 21,
    parameter int D_W = 6
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire  [N_W-1:0]   i_num,
    input  wire  [D_W-1:0]   i_den,
    output logic             o_done,
    output logic [N_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [D_W-1:0]   r_rem;
    logic [N_W-1:0]   r_quot;
    logic [D_W-1:0]   r_den;

    logic [D_W:0]     w_trial;
    logic [D_W:0]     w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_quot[N_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
            r_quot <= {r_quot[N_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

### hdl/moving_average_filter_bank.sv
// moving_average_filter_bank: multichannel boxcar average with per-channel ring,
// running sum and pointer. Depends on mavg_pkg, mavg_ram, mavg_div.
// Words are handled one at a time: a new word is accepted only after the last result
// has moved to the output register, so divider work and output stalls hold the input.
// Reset: a clearing pass over every ring address zeroes the
// ring and channel state; no input word is accepted until it finishes.
`timescale 1ns / 1ps
`default_nettype none

module moving_average_filter_bank
    import mavg_pkg::*;
#(
    parameter int CHANNELS   = DEF_CHANNELS,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wr_en,
    input  wire  [WIN_W-1:0]     i_cfg_wr_data,
    input  wire                  i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  wire  [TDATA_W-1:0]   i_s_axis_tdata,  // channel[4:0], sample[20:5], zero pad
    output logic                 o_m_axis_tvalid,
    input  wire                  i_m_axis_tready,
    output logic [TDATA_W-1:0]   o_m_axis_tdata   // channel_out[4:0], average[20:5], zero pad
);

    localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int SUM_W   = SMP_W + PTR_W;
    localparam int META_W  = SUM_W + PTR_W;
    localparam int RING_AW = CH_AW + PTR_W;
    localparam int PC_W    = ((PTR_W > WIN_W) ? PTR_W : WIN_W) + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_META  = 3'd2;
    localparam logic [2:0] S_RING  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [RING_AW-1:0] r_clr;
    logic [WIN_W-1:0]   r_window;
    logic [CH_W-1:0]    r_ch;
    logic [SMP_W-1:0]   r_smp;
    logic [SUM_W-1:0]   r_sum;
    logic [PTR_W-1:0]   r_ptr;
    logic [AVG_W-1:0]   r_res;
    logic               r_out_valid;
    logic [CH_W-1:0]    r_out_ch;
    logic [AVG_W-1:0]   r_out_avg;

    logic [CH_W-1:0]    w_in_ch;
    logic [SMP_W-1:0]   w_in_smp;
    logic               w_accept;
    logic               w_in_range;
    logic [CH_AW-1:0]   w_ch_idx;
    logic [WIN_W-1:0]   w_win_cap;
    logic [WIN_W-1:0]   w_win;
    logic               w_out_free;

    logic [META_W-1:0]  w_meta_rdata;
    logic [SMP_W-1:0]   w_ring_rdata;
    logic [SUM_W-1:0]   w_new_sum;
    logic [PC_W-1:0]    w_ptr_inc;
    logic [PC_W-1:0]    w_ptr_wrap;
    logic [PTR_W-1:0]   w_new_ptr;

    logic               w_ring_we;
    logic [RING_AW-1:0] w_ring_waddr;
    logic [SMP_W-1:0]   w_ring_wdata;
    logic               w_meta_we;
    logic [CH_AW-1:0]   w_meta_waddr;
    logic [META_W-1:0]  w_meta_wdata;

    logic               w_div_start;
    logic               w_div_done;
    logic [SUM_W-1:0]   w_div_quot;

    assign w_in_ch    = i_s_axis_tdata[CH_W-1:0];
    assign w_in_smp   = i_s_axis_tdata[CH_W +: SMP_W];
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_range = (int'(w_in_ch) < CHANNELS);
    assign w_ch_idx   = CH_AW'(r_ch);
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // window saturates at buffer depth, zero acts as one
    assign w_win_cap = (int'(r_window) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : r_window;
    assign w_win     = (w_win_cap == '0) ? WIN_W'(1) : w_win_cap;

    assign w_new_sum  = r_sum - SUM_W'(w_ring_rdata) + SUM_W'(r_smp);
    assign w_ptr_inc  = PC_W'(r_ptr) + PC_W'(1);
    assign w_ptr_wrap = (w_ptr_inc >= PC_W'(w_win)) ? (w_ptr_inc - PC_W'(w_win)) : w_ptr_inc;
    assign w_new_ptr  = w_ptr_wrap[PTR_W-1:0];

    assign w_ring_we    = (r_state == S_CLEAR) || (r_state == S_RING);
    assign w_ring_waddr = (r_state == S_CLEAR) ? r_clr : {w_ch_idx, r_ptr};
    assign w_ring_wdata = (r_state == S_CLEAR) ? '0 : r_smp;

    assign w_meta_we    = ((r_state == S_CLEAR) && (r_clr[RING_AW-1:CH_AW] == '0))
                          || (r_state == S_RING);
    assign w_meta_waddr = (r_state == S_CLEAR) ? r_clr[CH_AW-1:0] : w_ch_idx;
    assign w_meta_wdata = (r_state == S_CLEAR) ? '0 : {w_new_ptr, w_new_sum};

    assign w_div_start = (r_state == S_RING);

    mavg_ram #(
        .WIDTH (SMP_W),
        .DEPTH (1 << RING_AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ring_we),
        .i_waddr (w_ring_waddr),
        .i_wdata (w_ring_wdata),
        .i_re    (r_state == S_META),
        .i_raddr ({w_ch_idx, w_meta_rdata[META_W-1:SUM_W]}),
        .o_rdata (w_ring_rdata)
    );

    mavg_ram #(
        .WIDTH (META_W),
        .DEPTH (1 << CH_AW)
    ) u_meta (
        .i_clk   (i_clk),
        .i_we    (w_meta_we),
        .i_waddr (w_meta_waddr),
        .i_wdata (w_meta_wdata),
        .i_re    (w_accept),
        .i_raddr (CH_AW'(w_in_ch)),
        .o_rdata (w_meta_rdata)
    );

    mavg_div #(
        .N_W (SUM_W),
        .D_W (WIN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_new_sum),
        .i_den   (w_win),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_range ? S_META : S_DONE;
                end
            end
            S_META:  n_state = S_RING;
            S_RING:  n_state = S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_window    <= WIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch  <= w_in_ch;
            r_smp <= w_in_smp;
            r_res <= '0;
        end
        if (r_state == S_META) begin
            r_sum <= w_meta_rdata[SUM_W-1:0];
            r_ptr <= w_meta_rdata[META_W-1:SUM_W];
        end
        if ((r_state == S_DIV) && w_div_done) begin
            r_res <= (w_div_quot[SUM_W-1:AVG_W] != '0) ? '1 : w_div_quot[AVG_W-1:0];
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_ch  <= r_ch;
            r_out_avg <= r_res;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(TDATA_W - CH_W - AVG_W){1'b0}}, r_out_avg, r_out_ch};

endmodule

`default_nettype wire

### verif/testbench.sv
// testbench: self-checking bench for moving_average_filter_bank. Drives directed and
// random sample words with random stalls, predicts each average, checks every result.
// Depends on mavg_pkg and the filter bank RTL.
`timescale 1ns / 1ps

module testbench;
    import mavg_pkg::*;

    localparam int CHANNELS  = DEF_CHANNELS;
    localparam int MAX_WIN   = DEF_MAX_WINDOW;
    localparam int LATENCY   = 40;
    localparam int LIMIT     = 400000;
    localparam int NDIR      = 21;
    localparam int NPHASE    = 8;
    localparam int PHASE_LEN = 100;
    localparam int NO_EXP    = -1;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [AVG_W-1:0] avg;
    } t_avg_word;

    typedef struct packed {
        logic             do_cfg;
        logic [WIN_W-1:0] win;
        logic [CH_W-1:0]  ch;
        logic [SMP_W-1:0] smp;
        int               exp_avg;
    } t_stim_row;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_en = 1'b0;
    logic [WIN_W-1:0]   cfg_data = '0;
    logic               s_valid = 1'b0;
    logic [TDATA_W-1:0] s_data = '0;
    logic               m_ready = 1'b0;
    wire                s_ready;
    wire                m_valid;
    wire  [TDATA_W-1:0] m_data;

    logic [SMP_W-1:0]   ring_mdl [CHANNELS][MAX_WIN];
    int unsigned        sum_mdl [CHANNELS];
    int unsigned        ptr_mdl [CHANNELS];
    logic [WIN_W-1:0]   win_mdl;

    t_avg_word          pending_avg [$];
    t_stim_row          dir_tab [NDIR];
    bit                 idle_en = 1'b1;
    int                 err_cnt = 0;
    int                 stall_cnt = 0;
    int                 cycle_cnt = 0;

    moving_average_filter_bank dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_en),
        .i_cfg_wr_data   (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // channel[4:0], sample[20:5], zero pad
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)    // channel_out[4:0], average[20:5], zero pad
    );

    always #5 clk = ~clk;

    function automatic t_avg_word predict_avg(input logic [CH_W-1:0] ch,
                                              input logic [SMP_W-1:0] smp);
        t_avg_word   res;
        int unsigned w;
        int unsigned p;
        int unsigned q;
        res.ch  = ch;
        res.avg = '0;
        if (32'(ch) >= CHANNELS) begin
            return res;
        end
        w = 32'(win_mdl);
        if (w > MAX_WIN) begin
            w = MAX_WIN;
        end
        if (w == 0) begin
            w = 1;
        end
        p = ptr_mdl[ch];
        if (p >= MAX_WIN) begin
            p = 0;
        end
        sum_mdl[ch] = sum_mdl[ch] - 32'(ring_mdl[ch][p]) + 32'(smp);
        ring_mdl[ch][p] = smp;
        p = p + 1;
        if (p >= w) begin
            p = p - w;
        end
        ptr_mdl[ch] = p;
        q = sum_mdl[ch] / w;
        if (q > 32'hFFFF) begin
            q = 32'hFFFF;
        end
        res.avg = q[AVG_W-1:0];
        return res;
    endfunction

    // drain, then write the window register while the block is idle
    task automatic write_window(input logic [WIN_W-1:0] win);
        s_valid <= 1'b0;
        while (pending_avg.size() != 0) begin
            @(posedge clk);
        end
        cfg_en   <= 1'b1;
        cfg_data <= win;
        @(posedge clk);
        cfg_en   <= 1'b0;
        win_mdl = win;
    endtask

    task automatic send_word(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp,
                             input int exp_avg);
        t_avg_word w;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        w = predict_avg(ch, smp);
        if (exp_avg != NO_EXP) begin
            w.avg = exp_avg[AVG_W-1:0];
        end
        pending_avg.push_back(w);
        s_valid <= 1'b1;
        s_data  <= {{(TDATA_W-CH_W-SMP_W){1'b0}}, smp, ch};
        do @(posedge clk); while (!s_ready);
    endtask

    // result checker and receiver stall generator
    always @(posedge clk) begin
        t_avg_word exp_w;
        if (rst_n && m_valid && m_ready) begin
            if (pending_avg.size() == 0) begin
                $error("unexpected word: channel_out %0d average %0d",
                       m_data[CH_W-1:0], m_data[CH_W+AVG_W-1:CH_W]);
                err_cnt = err_cnt + 1;
            end else begin
                exp_w = pending_avg.pop_front();
                if (m_data[CH_W-1:0] !== exp_w.ch) begin
                    $error("channel_out: expected %0d, got %0d", exp_w.ch, m_data[CH_W-1:0]);
                    err_cnt = err_cnt + 1;
                end
                if (m_data[CH_W+AVG_W-1:CH_W] !== exp_w.avg) begin
                    $error("average: expected %0d, got %0d", exp_w.avg,
                           m_data[CH_W+AVG_W-1:CH_W]);
                    err_cnt = err_cnt + 1;
                end
            end
        end
        if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            m_ready   <= (stall_cnt == 1);
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_cnt <= int'($urandom_range(1, 6));
            m_ready   <= 1'b0;
        end else begin
            m_ready   <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int               k;
        int               n;
        int               ph;
        logic [CH_W-1:0]  ch;
        logic [SMP_W-1:0] smp;
        for (k = 0; k < CHANNELS; k++) begin
            sum_mdl[k] = 0;
            ptr_mdl[k] = 0;
            for (n = 0; n < MAX_WIN; n++) begin
                ring_mdl[k][n] = '0;
            end
        end
        win_mdl = WIN_RESET;

        // do_cfg, window, channel, sample, expected average
        dir_tab[0]  = '{1'b0, 6'd0,  5'd0,  16'h0000, 0};
        dir_tab[1]  = '{1'b0, 6'd0,  5'd31, 16'hFFFF, 8191};
        dir_tab[2]  = '{1'b0, 6'd0,  5'd31, 16'hFFFF, 16383};
        dir_tab[3]  = '{1'b0, 6'd0,  5'd31, 16'h00FF, NO_EXP};
        dir_tab[4]  = '{1'b0, 6'd0,  5'd7,  16'hAAAA, NO_EXP};
        dir_tab[5]  = '{1'b0, 6'd0,  5'd24, 16'h5555, NO_EXP};
        dir_tab[6]  = '{1'b1, 6'd1,  5'd5,  16'hFFFF, 65535};
        dir_tab[7]  = '{1'b0, 6'd0,  5'd5,  16'd12345, 12345};
        // pointer beyond a shrunk window, stale entries saturate the average
        dir_tab[8]  = '{1'b0, 6'd0,  5'd31, 16'hFFFF, 65535};
        dir_tab[9]  = '{1'b0, 6'd0,  5'd31, 16'h0000, 65535};
        // window of zero acts as one
        dir_tab[10] = '{1'b1, 6'd0,  5'd5,  16'h5555, 21845};
        // window above buffer depth saturates
        dir_tab[11] = '{1'b1, 6'd63, 5'd10, 16'hFFFF, 2047};
        dir_tab[12] = '{1'b0, 6'd0,  5'd10, 16'hFFFF, 4095};
        dir_tab[13] = '{1'b1, 6'd32, 5'd10, 16'h0001, NO_EXP};
        dir_tab[14] = '{1'b1, 6'd2,  5'd31, 16'hFFFF, NO_EXP};
        dir_tab[15] = '{1'b0, 6'd0,  5'd31, 16'h1234, NO_EXP};
        dir_tab[16] = '{1'b0, 6'd0,  5'd31, 16'h0000, NO_EXP};
        dir_tab[17] = '{1'b0, 6'd0,  5'd31, 16'h0000, NO_EXP};
        dir_tab[18] = '{1'b1, 6'd8,  5'd0,  16'hFFFF, NO_EXP};
        dir_tab[19] = '{1'b0, 6'd0,  5'd16, 16'h8000, NO_EXP};
        dir_tab[20] = '{1'b0, 6'd0,  5'd15, 16'h7FFF, NO_EXP};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < NDIR; k++) begin
            if (dir_tab[k].do_cfg) begin
                write_window(dir_tab[k].win);
            end
            send_word(dir_tab[k].ch, dir_tab[k].smp, dir_tab[k].exp_avg);
        end

        for (ph = 0; ph < NPHASE; ph++) begin
            case (ph)
                0: begin
                    write_window(6'd1);
                end
                1: begin
                    write_window(6'd32);
                end
                2: begin
                    write_window(6'd63);
                end
                3: begin
                    write_window(6'd0);
                end
                default: begin
                    write_window(WIN_W'($urandom_range(0, 63)));
                end
            endcase
            if (ph == NPHASE - 1) begin
                idle_en = 1'b0;
            end
            for (n = 0; n < PHASE_LEN; n++) begin
                // mostly a few channels so windows fill and wrap
                if ($urandom_range(0, 3) != 0) begin
                    ch = CH_W'($urandom_range(0, 3));
                end else begin
                    ch = CH_W'($urandom_range(0, CHANNELS - 1));
                end
                case ($urandom_range(0, 7))
                    0, 1: begin
                        smp = 16'hFFFF;
                    end
                    2: begin
                        smp = 16'h0000;
                    end
                    default: begin
                        smp = SMP_W'($urandom_range(0, 65535));
                    end
                endcase
                send_word(ch, smp, NO_EXP);
            end
        end

        s_valid <= 1'b0;
        while (pending_avg.size() != 0) begin
            @(posedge clk);
        end
        repeat (LATENCY) @(posedge clk);

        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
